@@ hw/rtl/mfmenc_pkg.sv @@
// Shared types, command codes, constants and bit functions for the MFM byte encoder.
// No dependencies; used by every module of the encoder.
`default_nettype none

package mfmenc_pkg;

  // Command codes carried in the func field of an input request.
  localparam logic [2:0] FUNC_PLAIN      = 3'd0;
  localparam logic [2:0] FUNC_CRC_BYTE   = 3'd1;
  localparam logic [2:0] FUNC_A1_RESTART = 3'd2;
  localparam logic [2:0] FUNC_A1_CONT    = 3'd3;
  localparam logic [2:0] FUNC_C2         = 3'd4;
  localparam logic [2:0] FUNC_EMIT_CRC   = 3'd5;
  // Codes with no meaning: no word comes out and the encoder state stays put.
  localparam logic [2:0] FUNC_UNUSED_LO  = 3'd6;
  localparam logic [2:0] FUNC_UNUSED_HI  = 3'd7;

  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] A1_RAW   = 16'h4489;
  localparam logic [15:0] C2_RAW   = 16'h5224;
  localparam logic [7:0]  A1_DATA  = 8'hA1;

  // Default depth of the result queue; at least two so a CRC pair fits.
  localparam int QUEUE_DEPTH_DEF = 4;

  typedef struct packed {
    logic [2:0] func;
    logic [7:0] data_byte;
  } in_req_t;

  typedef struct packed {
    logic [15:0] raw_word;
    logic        last;
  } out_req_t;

  // Results produced by one command, handed from the encoder to the queue.
  typedef struct packed {
    logic [1:0] cnt;
    out_req_t   w0;
    out_req_t   w1;
  } push_t;

  typedef struct packed {
    logic [15:0] word;
    logic        last_bit;
  } mfm_res_t;

  // Folds one byte into a CRC-16-CCITT, most significant bit first.
  function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] r;
    r = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      r = r[15] ? ((r << 1) ^ CRC_POLY) : (r << 1);
    end
    return r;
  endfunction

  // MFM cells for one byte, first cell in the top bit, plus the final data bit.
  function automatic mfm_res_t mfm_encode(input logic [7:0] b, input logic prev);
    mfm_res_t res;
    logic     p;
    p = prev;
    res.word = '0;
    for (int i = 7; i >= 0; i--) begin
      res.word[2*i+1] = ~b[i] & ~p;
      res.word[2*i]   = b[i];
      p = b[i];
    end
    res.last_bit = p;
    return res;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/mfmenc_core.sv @@
// Command decoder with the running CRC and last-data-bit state.
// Depends on mfmenc_pkg for codes, types and the MFM and CRC functions.
`default_nettype none

module mfmenc_core
  import mfmenc_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    adv,
  input  wire in_req_t item,
  output push_t        push
);

  logic [15:0] crc_r, crc_nxt;
  logic        prev_r, prev_nxt;
  mfm_res_t    byte_enc, hi_enc, lo_enc;

  always_comb begin
    byte_enc = mfm_encode(item.data_byte, prev_r);
    hi_enc   = mfm_encode(crc_r[15:8], prev_r);
    lo_enc   = mfm_encode(crc_r[7:0], hi_enc.last_bit);
  end

  always_comb begin
    crc_nxt     = crc_r;
    prev_nxt    = prev_r;
    push.cnt    = 2'd0;
    push.w0     = '{raw_word: byte_enc.word, last: 1'b1};
    push.w1     = '{raw_word: lo_enc.word, last: 1'b1};
    case (item.func)
      FUNC_PLAIN: begin
        push.cnt = 2'd1;
        prev_nxt = byte_enc.last_bit;
      end
      FUNC_CRC_BYTE: begin
        push.cnt = 2'd1;
        prev_nxt = byte_enc.last_bit;
        crc_nxt  = crc_fold(crc_r, item.data_byte);
      end
      FUNC_A1_RESTART: begin
        push.cnt = 2'd1;
        push.w0  = '{raw_word: A1_RAW, last: 1'b1};
        prev_nxt = 1'b1;
        crc_nxt  = crc_fold(CRC_INIT, A1_DATA);
      end
      FUNC_A1_CONT: begin
        push.cnt = 2'd1;
        push.w0  = '{raw_word: A1_RAW, last: 1'b1};
        prev_nxt = 1'b1;
        crc_nxt  = crc_fold(crc_r, A1_DATA);
      end
      FUNC_C2: begin
        push.cnt = 2'd1;
        push.w0  = '{raw_word: C2_RAW, last: 1'b1};
        prev_nxt = 1'b0;
      end
      FUNC_EMIT_CRC: begin
        push.cnt = 2'd2;
        push.w0  = '{raw_word: hi_enc.word, last: 1'b0};
        prev_nxt = lo_enc.last_bit;
      end
      default: begin
        push.cnt = 2'd0;
      end
    endcase
    if (!adv) begin
      push.cnt = 2'd0;
      crc_nxt  = crc_r;
      prev_nxt = prev_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r  <= CRC_INIT;
      prev_r <= 1'b0;
    end else begin
      crc_r  <= crc_nxt;
      prev_r <= prev_nxt;
    end
  end

`ifndef SYNTHESIS
  a_emit_keeps_crc: assert property (@(posedge clk) disable iff (!rst_n)
    adv && item.func == FUNC_EMIT_CRC |=> $stable(crc_r))
    else $error("CRC changed while it was being emitted");
  a_a1_sets_prev: assert property (@(posedge clk) disable iff (!rst_n)
    adv && (item.func == FUNC_A1_RESTART || item.func == FUNC_A1_CONT) |=> prev_r)
    else $error("A1 mark did not leave the last data bit at one");
  a_unused_no_push: assert property (@(posedge clk) disable iff (!rst_n)
    adv && (item.func == FUNC_UNUSED_LO || item.func == FUNC_UNUSED_HI) |-> push.cnt == 2'd0)
    else $error("unused command produced a result");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/mfmenc_queue.sv @@
// Result queue that takes up to two words a cycle and delivers one while out_stall is low.
// Depends on mfmenc_pkg for the push and result request types.
`default_nettype none

module mfmenc_queue
  import mfmenc_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire push_t push,
  output logic       room2,
  output logic       out_valid,
  input  wire logic  out_stall,
  output out_req_t   out_req
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  out_req_t        mem [DEPTH];
  logic [AW-1:0]   wp_r, wp_nxt, wp1, rp_r, rp_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic            pop;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign room2     = (count_r <= CW'(DEPTH - 2));
  assign out_valid = (count_r != '0);
  assign out_req   = mem[rp_r];
  assign pop       = out_valid & ~out_stall;
  assign wp1       = ptr_inc(wp_r);

  always_comb begin
    rp_nxt    = pop ? ptr_inc(rp_r) : rp_r;
    wp_nxt    = wp_r;
    case (push.cnt)
      2'd1:    wp_nxt = wp1;
      2'd2:    wp_nxt = ptr_inc(wp1);
      default: wp_nxt = wp_r;
    endcase
    count_nxt = count_r + CW'(push.cnt) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem[wp_r] <= push.w0;
    end
    if (push.cnt == 2'd2) begin
      mem[wp1] <= push.w1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r    <= '0;
      rp_r    <= '0;
      count_r <= '0;
    end else begin
      wp_r    <= wp_nxt;
      rp_r    <= rp_nxt;
      count_r <= count_nxt;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("result queue holds more than its depth");
  a_push_fits: assert property (@(posedge clk) disable iff (!rst_n)
    push.cnt != 2'd0 |-> room2)
    else $error("push into a queue without room for a pair");
  a_pop_only: assert property (@(posedge clk) disable iff (!rst_n)
    pop && push.cnt == 2'd0 |=> count_r == $past(count_r) - 1'b1)
    else $error("queue count did not drop on a lone pop");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/mfm_byte_encoder_with_crc.sv @@
// An accepted request goes into the input register, then its words pass through the queue.
// Throughput: one request and one word per cycle unless stalled; emit-CRC gives two words.
// The input stalls while a request is parked and fewer than two queue entries are free.
// Reset (rst_n low, synchronous) clears the queue, sets the CRC to 0xFFFF and the
// last data bit to zero; the input register is emptied.
// Depends on mfmenc_pkg, mfmenc_core and mfmenc_queue.
`default_nettype none

module mfm_byte_encoder_with_crc
  import mfmenc_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_stall,
  input  wire in_req_t in_req,
  output logic         out_valid,
  input  wire logic    out_stall,
  output out_req_t     out_req
);

  // The input register holds one request until the queue has room for
  // everything it can produce, which is at most two words.
  in_req_t item_r, item_nxt;
  logic    item_vld_r, item_vld_nxt;
  logic    room2;
  logic    adv;
  logic    in_acc;
  push_t   push;

  // The request in the register moves on whenever the queue can take a pair.
  // The stall therefore only rises when a request is parked and fewer than two
  // queue entries are free.
  assign adv      = item_vld_r & room2;
  assign in_stall = item_vld_r & ~room2;
  assign in_acc   = in_valid & ~in_stall;

  always_comb begin
    item_nxt     = in_acc ? in_req : item_r;
    item_vld_nxt = in_acc | (item_vld_r & ~adv);
  end

  // The payload register needs no reset; only its valid flag is control state.
  always_ff @(posedge clk) begin
    item_r <= item_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
    end else begin
      item_vld_r <= item_vld_nxt;
    end
  end

  // Command decode, MFM cell generation and CRC update, all in one pass.
  mfmenc_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .item  (item_r),
    .push  (push)
  );

  // The queue decouples the result side, so a waiting word blocks the input
  // only once the queue is nearly full.
  mfmenc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room2     (room2),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_req   (out_req)
  );

endmodule

`default_nettype wire
